@@ src/hpt_pkg.sv @@
// Shared types and constants for the homogeneous point transform.
// No dependencies; every other source file imports this package.
`default_nettype none

package hpt_pkg;

  localparam int FRAC_BITS_DEF = 16;   // Q16.16
  localparam int FRAC_BITS_MAX = 24;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int COORD_W   = 32;
  localparam int MAG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 64;

  // Front pipeline depth, used by the checker to bound occupancy.
  localparam int FRONT_STAGES = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_00_01 = 3'd0,
    CFG_COEF_02_10 = 3'd1,
    CFG_COEF_11_12 = 3'd2,
    CFG_COEF_20_21 = 3'd3,
    CFG_COEF_22    = 3'd4
  } cfg_reg_t;

  // One classified point, handed from the front end to the divider.
  typedef struct packed {
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
    logic [MAG_W-1:0] den;
    logic             neg_x;
    logic             neg_y;
    logic             divided;
  } hpt_entry_t;

endpackage : hpt_pkg

`default_nettype wire

@@ src/hpt_front.sv @@
// Front end: matrix registers, row products, row sums and sign/magnitude split.
// Depends on hpt_pkg; feeds hpt_queue.
`default_nettype none

module hpt_front import hpt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DW-1:0]        cfg_wdata,
  input  wire logic                     in_valid,
  output      logic                     in_ready,
  input  wire logic signed [COORD_W-1:0] in_point_x,
  input  wire logic signed [COORD_W-1:0] in_point_y,
  input  wire logic                     q_full,
  output      logic                     push_valid,
  output      hpt_entry_t               push_data
);

  localparam int SUM_W = 2 * COORD_W + 2;
  localparam logic [CFG_DW-1:0]  ONE_HI  = 64'd1 << (COORD_W + FRAC_BITS);
  localparam logic [COORD_W-1:0] ONE_LO  = 32'd1 << FRAC_BITS;
  // Divisor standing in for a zero w: n * 2^F / 2^(2F) is n >> F.
  localparam logic [MAG_W-1:0]   WZ_DEN  = 64'd1 << (2 * FRAC_BITS);

  logic [CFG_DW-1:0]  coef_00_01_r, coef_02_10_r, coef_11_12_r, coef_20_21_r;
  logic [COORD_W-1:0] coef_22_r;

  logic signed [COORD_W-1:0] ca [3];
  logic signed [COORD_W-1:0] cb [3];
  logic signed [COORD_W-1:0] cc [3];

  logic                        f1_vld_r, f2_vld_r, f3_vld_r;
  logic signed [2*COORD_W-1:0] mul_a_r [3];
  logic signed [2*COORD_W-1:0] mul_b_r [3];
  logic signed [COORD_W-1:0]   cst_r   [3];
  logic signed [SUM_W-1:0]     sum_r   [3];
  hpt_entry_t                  ent_r, ent_nxt;

  logic       front_en;
  logic [2:0] neg, nz;
  logic [MAG_W-1:0] mag [3];
  logic       wz;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_00_01_r <= ONE_HI;
      coef_02_10_r <= '0;
      coef_11_12_r <= ONE_HI;
      coef_20_21_r <= '0;
      coef_22_r    <= ONE_LO;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COEF_00_01: coef_00_01_r <= cfg_wdata;
        CFG_COEF_02_10: coef_02_10_r <= cfg_wdata;
        CFG_COEF_11_12: coef_11_12_r <= cfg_wdata;
        CFG_COEF_20_21: coef_20_21_r <= cfg_wdata;
        CFG_COEF_22:    coef_22_r    <= cfg_wdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ca[0] = coef_00_01_r[63:32];
    cb[0] = coef_00_01_r[31:0];
    cc[0] = coef_02_10_r[63:32];
    ca[1] = coef_02_10_r[31:0];
    cb[1] = coef_11_12_r[63:32];
    cc[1] = coef_11_12_r[31:0];
    ca[2] = coef_20_21_r[63:32];
    cb[2] = coef_20_21_r[31:0];
    cc[2] = coef_22_r;
  end

  // The whole front advances together; hold when the last stage cannot push.
  assign front_en   = !f3_vld_r || !q_full;
  assign in_ready   = front_en;
  assign push_valid = f3_vld_r && !q_full;
  assign push_data  = ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
      f3_vld_r <= 1'b0;
    end else if (front_en) begin
      f1_vld_r <= in_valid;
      f2_vld_r <= f1_vld_r;
      f3_vld_r <= f2_vld_r;
    end
  end

  // Classify: sign/magnitude per row, substitute divisor for zero w.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      neg[r] = sum_r[r][SUM_W-1];
      nz[r]  = (sum_r[r] != '0);
      mag[r] = neg[r] ? (~sum_r[r][MAG_W-1:0] + 64'd1) : sum_r[r][MAG_W-1:0];
    end
    wz              = !nz[2];
    ent_nxt.mag_x   = mag[0];
    ent_nxt.mag_y   = mag[1];
    ent_nxt.den     = wz ? WZ_DEN : mag[2];
    ent_nxt.neg_x   = nz[0] && (neg[0] ^ (neg[2] && !wz));
    ent_nxt.neg_y   = nz[1] && (neg[1] ^ (neg[2] && !wz));
    ent_nxt.divided = !wz;
  end

  always_ff @(posedge clk) begin
    if (front_en) begin
      for (int r = 0; r < 3; r++) begin
        mul_a_r[r] <= ca[r] * in_point_x;
        mul_b_r[r] <= cb[r] * in_point_y;
        cst_r[r]   <= cc[r];
        sum_r[r]   <= SUM_W'(mul_a_r[r]) + SUM_W'(mul_b_r[r])
                      + (SUM_W'(cst_r[r]) <<< FRAC_BITS);
      end
      ent_r <= ent_nxt;
    end
  end

endmodule : hpt_front

`default_nettype wire

@@ src/hpt_queue.sv @@
// Short FIFO of classified points between front end and divider.
// Depends on hpt_pkg.
`default_nettype none

module hpt_queue import hpt_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire hpt_entry_t push_data,
  output      logic       full,
  input  wire logic       pop,
  output      hpt_entry_t head,
  output      logic       empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  hpt_entry_t       slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + CNT_W'(1);
    if (pop && !push) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule : hpt_queue

`default_nettype wire

@@ src/hpt_back.sv @@
// Back end: pipelined restoring divider (one quotient bit per stage, both
// coordinates in parallel), clamp and output register. Depends on hpt_pkg.
`default_nettype none

module hpt_back import hpt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire hpt_entry_t                head,
  input  wire logic                      q_empty,
  output      logic                      q_pop,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      logic signed [COORD_W-1:0] out_x,
  output      logic signed [COORD_W-1:0] out_y,
  output      logic                      out_divided,
  output      logic                      out_saturated
);

  localparam int NSTEP = MAG_W + FRAC_BITS;
  localparam int QW    = COORD_W + 1;

  typedef struct packed {
    logic [MAG_W-1:0] num;   // numerator, shifted out from the top
    logic [MAG_W-1:0] rem;
    logic [QW-1:0]    quo;
    logic             over;  // quotient has passed 2^QW
    logic             neg;
  } lane_t;

  typedef struct packed {
    lane_t            lx;
    lane_t            ly;
    logic [MAG_W-1:0] den;
    logic             divided;
  } stage_t;

  function automatic lane_t lane_step(lane_t l, logic [MAG_W-1:0] den);
    logic [MAG_W:0] rs;
    logic [MAG_W:0] diff;
    logic           ge;
    lane_t          n;
    rs     = {l.rem, l.num[MAG_W-1]};
    diff   = rs - {1'b0, den};
    ge     = (rs >= {1'b0, den});
    n      = l;
    n.num  = l.num << 1;
    n.rem  = ge ? diff[MAG_W-1:0] : rs[MAG_W-1:0];
    n.quo  = {l.quo[QW-2:0], ge};
    n.over = l.over | l.quo[QW-1];
    return n;
  endfunction

  // Returns {saturated, value}.
  function automatic logic [COORD_W:0] clamp(lane_t l);
    logic big;
    if (!l.neg) begin
      big = l.over | l.quo[QW-1] | l.quo[QW-2];
      return big ? {1'b1, 32'h7FFF_FFFF} : {1'b0, l.quo[COORD_W-1:0]};
    end
    big = l.over | l.quo[QW-1] | (l.quo[QW-2] & (|l.quo[QW-3:0]));
    return big ? {1'b1, 32'h8000_0000} : {1'b0, -l.quo[COORD_W-1:0]};
  endfunction

  stage_t           st_r  [NSTEP];
  logic [NSTEP-1:0] vld_r;
  stage_t           st_in;
  logic             back_en;
  logic [COORD_W:0] cx, cy;

  logic                      out_valid_r;
  logic signed [COORD_W-1:0] out_x_r, out_y_r;
  logic                      out_divided_r, out_saturated_r;

  // Whole divider advances together; hold while the result is not taken.
  assign back_en = !out_valid_r || out_ready;
  assign q_pop   = back_en && !q_empty;

  always_comb begin
    st_in.lx      = '{num: head.mag_x, rem: '0, quo: '0, over: 1'b0, neg: head.neg_x};
    st_in.ly      = '{num: head.mag_y, rem: '0, quo: '0, over: 1'b0, neg: head.neg_y};
    st_in.den     = head.den;
    st_in.divided = head.divided;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (back_en) begin
      vld_r <= {vld_r[NSTEP-2:0], !q_empty};
    end
  end

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    stage_t src;
    if (k == 0) begin : g_first
      assign src = st_in;
    end else begin : g_next
      assign src = st_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (back_en) begin
        st_r[k].lx      <= lane_step(src.lx, src.den);
        st_r[k].ly      <= lane_step(src.ly, src.den);
        st_r[k].den     <= src.den;
        st_r[k].divided <= src.divided;
      end
    end
  end

  assign cx = clamp(st_r[NSTEP-1].lx);
  assign cy = clamp(st_r[NSTEP-1].ly);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (back_en) begin
      out_valid_r <= vld_r[NSTEP-1];
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      out_x_r         <= cx[COORD_W-1:0];
      out_y_r         <= cy[COORD_W-1:0];
      out_divided_r   <= st_r[NSTEP-1].divided;
      out_saturated_r <= cx[COORD_W] | cy[COORD_W];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_x         = out_x_r;
  assign out_y         = out_y_r;
  assign out_divided   = out_divided_r;
  assign out_saturated = out_saturated_r;

endmodule : hpt_back

`default_nettype wire

@@ src/homogeneous_point_transform_top.sv @@
// Top level of the homogeneous 2D point transform (3x3 matrix, Q format).
// Depends on hpt_pkg, hpt_front, hpt_queue and hpt_back.
//
//   channel | ports                        | width        | dir
//   --------+------------------------------+--------------+-----
//   input   | in_valid/in_ready, in_point_*| 2 x 32 signed| in
//   result  | out_valid/out_ready, out_*   | 2 x 32 + 2   | out
//   config  | cfg_we, cfg_index, cfg_wdata | 3 + 64       | in
//
// Throughput is one beat per cycle in and out while out_ready is held high.
// Beats pass the front registers, the queue, the divider (one restoring step per
// stage over 64 + FRAC_BITS stages, Q16.16 by default) and the output register.
// Reset (synchronous, rst_n low) loads the identity matrix and empties all
// stages. An output stall freezes the divider; the queue keeps absorbing
// front-end beats, and in_ready drops only once the queue is full.
`default_nettype none

module homogeneous_point_transform_top import hpt_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // configuration
  input  wire logic                      cfg_we,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DW-1:0]         cfg_wdata,
  // input beats
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire logic signed [COORD_W-1:0] in_point_x,
  input  wire logic signed [COORD_W-1:0] in_point_y,
  // result beats
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      logic signed [COORD_W-1:0] out_x,
  output      logic signed [COORD_W-1:0] out_y,
  output      logic                      out_divided,
  output      logic                      out_saturated
);

  logic       push_valid, q_full, q_empty, q_pop;
  hpt_entry_t push_data, q_head;

  // Front: hold coefficients, form x', y', w and classify the divide.
  hpt_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_point_x (in_point_x),
    .in_point_y (in_point_y),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  // Queue: decouple the front end from divider stalls.
  hpt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // Back: divide, clamp and present the result beat.
  hpt_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (q_head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_divided   (out_divided),
    .out_saturated (out_saturated)
  );

endmodule : homogeneous_point_transform_top

`default_nettype wire

@@ src/hpt_checker.sv @@
// Port-level checks for homogeneous_point_transform_top, bound to the top.
// Depends on hpt_pkg.
`default_nettype none

module hpt_checker import hpt_pkg::*; (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic signed [COORD_W-1:0] out_x,
  input wire logic signed [COORD_W-1:0] out_y,
  input wire logic                      out_divided,
  input wire logic                      out_saturated
);

  localparam int OCC_MAX = FRONT_STAGES + QUEUE_DEPTH_DEF + MAG_W + FRAC_BITS_MAX + 1;
  localparam logic signed [COORD_W-1:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] S_MIN = 32'sh8000_0000;

  logic [7:0] occ_r, occ_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    occ_nxt = occ_r;
    if (in_acc && !out_acc) occ_nxt = occ_r + 8'd1;
    if (out_acc && !in_acc) occ_nxt = occ_r - 8'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before the beat was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_x) && $stable(out_y)
      && $stable(out_divided) && $stable(out_saturated))
    else $error("result payload changed while stalled");

  a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_x == S_MAX || out_x == S_MIN || out_y == S_MAX || out_y == S_MIN)
    else $error("saturated flag without a clamped coordinate");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> occ_r != 8'd0)
    else $error("result beat with no point outstanding");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= 8'(OCC_MAX))
    else $error("more points outstanding than the pipeline can hold");

endmodule : hpt_checker

bind homogeneous_point_transform_top hpt_checker u_hpt_checker (.*);

`default_nettype wire
